>>> rtl/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants for the epoch to calendar converter
// Widths, reciprocal constants for the constant dividers, stage payload types
// and the cumulative month table.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int EPOCH_W = 32;
    localparam int OFFS_W  = 17;
    localparam int LS_W    = 33;   // local seconds, never negative when used
    localparam int DAYS_W  = 17;
    localparam int SOD_W   = 17;
    localparam int D2K_W   = 16;   // days since 2000-01-01 inside the valid range
    localparam int YEAR_W  = 12;

    // x / 675 = (x * RECIP_675) >> 36, exact for x < 2**26  (86400 = 675 << 7)
    localparam logic [26:0] RECIP_675   = 27'd101806633;
    localparam int          SH_675      = 36;
    // x / 15, exact for x < 2**15
    localparam logic [15:0] RECIP_15_W  = 16'd34953;
    localparam int          SH_15_W     = 19;
    // x / 15, exact for x < 2**9
    localparam logic [9:0]  RECIP_15_N  = 10'd547;
    localparam int          SH_15_N     = 13;
    // x / 1461 (days in a four-year cycle), exact for x < 2**16
    localparam logic [16:0] RECIP_1461  = 17'd91868;
    localparam int          SH_1461     = 27;
    // x / 7, exact for x < 2**16
    localparam logic [16:0] RECIP_7     = 17'd74899;
    localparam int          SH_7        = 19;

    localparam logic [DAYS_W-1:0] DAYS_Y2000  = 17'd10957;  // 2000-01-01
    localparam logic [DAYS_W-1:0] DAYS_Y2099E = 17'd47481;  // 2099-12-31
    localparam logic [YEAR_W-1:0] YEAR_BASE   = 12'd2000;
    localparam logic [2:0]        WD_2000_OFS = 3'd5;       // 2000-01-01 was a Saturday

    typedef struct packed {
        logic              ok;
        logic [D2K_W-1:0]  d2k;
        logic [SOD_W-1:0]  sod;
    } split_t;

    typedef struct packed {
        logic              valid_res;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day_of_month;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic [2:0]        weekday;
    } result_t;

    // Day of year at which month idx+1 starts.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] s;
        begin
            case (idx)
                4'd0:    s = 9'd0;
                4'd1:    s = 9'd31;
                4'd2:    s = 9'd59;
                4'd3:    s = 9'd90;
                4'd4:    s = 9'd120;
                4'd5:    s = 9'd151;
                4'd6:    s = 9'd181;
                4'd7:    s = 9'd212;
                4'd8:    s = 9'd243;
                4'd9:    s = 9'd273;
                4'd10:   s = 9'd304;
                4'd11:   s = 9'd334;
                default: s = 9'd0;
            endcase
            if (leap && idx >= 4'd2)
            begin
                s = s + 9'd1;
            end
            return s;
        end
    endfunction

endpackage

>>> rtl/epoch_to_calendar_converter_core.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_converter_core: Unix epoch to local civil date and time
// Usage:
//   Input channel in_valid / in_ready carries one word, utc_epoch.
//   Output channel out_valid / out_ready carries one result word: valid_res,
//   year, month, day_of_month, hour, minute, second, weekday (Mon=1..Sun=7).
//   cfg_we writes cfg_wdata (signed seconds) into the UTC offset register;
//   write it only while the pipeline is empty.
//   Seven register stages lie between acceptance and out_valid (offset add,
//   1/86400 product, day split, reciprocal products, remainders, hour product
//   and year-in-cycle, month lookup into the output register). Throughput is
//   one word per cycle without stalls; the multiplier stages set the depth.
//   A zero epoch, negative local time or a year outside 2000..2099 gives a
//   word with valid_res low and all other fields zero.
//   Reset clears every stage valid bit and the offset register to zero.
//   When out_ready is low the words hold in place; empty stages still fill,
//   so up to seven words are held before in_ready drops.
// ----------------------------------------------------------------------------
module epoch_to_calendar_converter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [epc_pkg::OFFS_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [epc_pkg::EPOCH_W-1:0]   utc_epoch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          valid_res,
    output logic [epc_pkg::YEAR_W-1:0]    year,
    output logic [3:0]                    month,
    output logic [4:0]                    day_of_month,
    output logic [4:0]                    hour,
    output logic [5:0]                    minute,
    output logic [5:0]                    second,
    output logic [2:0]                    weekday
);
    import epc_pkg::*;

    logic [OFFS_W-1:0] offset_reg, offset_next;
    logic              mid_valid, mid_ready;
    split_t            mid_data;
    result_t           res;

    assign offset_next = cfg_we ? cfg_wdata : offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    epc_day_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .utc_epoch  (utc_epoch),
        .utc_offset (offset_reg),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_data   (mid_data)
    );

    epc_calendar u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res)
    );

    assign valid_res    = res.valid_res;
    assign year         = res.year;
    assign month        = res.month;
    assign day_of_month = res.day_of_month;
    assign hour         = res.hour;
    assign minute       = res.minute;
    assign second       = res.second;
    assign weekday      = res.weekday;

endmodule

>>> rtl/epc_day_split.sv
// ----------------------------------------------------------------------------
// epc_day_split: local seconds and day / second-of-day split
// Three stages: offset add, reciprocal multiply by 1/86400, remainder and
// range check. Each stage has its own valid bit; bubbles collapse on stall.
// ----------------------------------------------------------------------------
module epc_day_split (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [epc_pkg::EPOCH_W-1:0]   utc_epoch,
    input  logic [epc_pkg::OFFS_W-1:0]    utc_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output epc_pkg::split_t               out_data
);
    import epc_pkg::*;

    logic [2:0] vld_reg;
    logic       adv0, adv1, adv2;

    logic [LS_W-1:0]   ls0_reg, ls0_next;
    logic              bad0_reg, bad0_next;
    logic [52:0]       prod1_reg, prod1_next;
    logic [LS_W-1:0]   ls1_reg;
    logic              bad1_reg;
    split_t            res2_reg, res2_next;

    logic [33:0]       loc_sec;
    logic [DAYS_W-1:0] days;
    logic [26:0]       hi_rem;

    assign adv2     = !vld_reg[2] || out_ready;
    assign adv1     = !vld_reg[1] || adv2;
    assign adv0     = !vld_reg[0] || adv1;
    assign in_ready = adv0;

    // stage 0: signed add, negative result flagged through bit 33
    always_comb
    begin
        loc_sec   = {2'b00, utc_epoch} + {{(34-OFFS_W){utc_offset[OFFS_W-1]}}, utc_offset};
        ls0_next  = loc_sec[LS_W-1:0];
        bad0_next = (utc_epoch == '0) || loc_sec[33];
    end

    // stage 1: days = (ls >> 7) / 675
    assign prod1_next = 53'(ls0_reg[LS_W-1:7]) * 53'(RECIP_675);

    // stage 2: second of day and range check
    always_comb
    begin
        days          = prod1_reg[52:SH_675];
        hi_rem        = 27'(ls1_reg[LS_W-1:7]) - 27'(days) * 27'd675;
        res2_next.sod = {hi_rem[9:0], ls1_reg[6:0]};
        res2_next.d2k = D2K_W'(days - DAYS_Y2000);
        res2_next.ok  = !bad1_reg && (days >= DAYS_Y2000) && (days <= DAYS_Y2099E);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv0)
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv1)
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv2)
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            ls0_reg  <= ls0_next;
            bad0_reg <= bad0_next;
        end
        if (adv1)
        begin
            prod1_reg <= prod1_next;
            ls1_reg   <= ls0_reg;
            bad1_reg  <= bad0_reg;
        end
        if (adv2)
        begin
            res2_reg <= res2_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = res2_reg;

endmodule

>>> rtl/epc_calendar.sv
// ----------------------------------------------------------------------------
// epc_calendar: day count and second of day to civil fields
// Four stages: reciprocal products, remainders, hour product and year within
// the four-year cycle, then hour / minute and month lookup into the output
// register. Invalid words leave with every field zero.
// ----------------------------------------------------------------------------
module epc_calendar (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  epc_pkg::split_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output epc_pkg::result_t out_data
);
    import epc_pkg::*;

    logic [3:0] vld_reg;
    logic       adv0, adv1, adv2, adv3;

    // stage 0
    logic [30:0]      pmin0_reg, pmin0_next;
    logic [32:0]      pcyc0_reg, pcyc0_next;
    logic [32:0]      pwd0_reg, pwd0_next;
    logic [SOD_W-1:0] sod0_reg;
    logic [D2K_W-1:0] d2k0_reg;
    logic             ok0_reg;
    logic [D2K_W-1:0] wdx0;
    // stage 1
    logic [10:0]      mins1_reg, mins1_next;
    logic [5:0]       sec1_reg, sec1_next;
    logic [4:0]       cyc1_reg, cyc1_next;
    logic [10:0]      r1_reg, r1_next;
    logic [2:0]       wd1_reg, wd1_next;
    logic             ok1_reg;
    logic [D2K_W-1:0] wdx1;
    logic [12:0]      q7;
    // stage 2
    logic [18:0]       phr2_reg, phr2_next;
    logic [10:0]       mins2_reg;
    logic [5:0]        sec2_reg;
    logic [YEAR_W-1:0] year2_reg, year2_next;
    logic [8:0]        doy2_reg, doy2_next;
    logic              leap2_reg, leap2_next;
    logic [2:0]        wd2_reg;
    logic              ok2_reg;
    logic [1:0]        yi;
    // stage 3
    result_t           res3_reg, res3_next;
    logic [4:0]        hour3;
    logic [3:0]        mi;
    logic [8:0]        mstart;

    assign adv3     = !vld_reg[3] || out_ready;
    assign adv2     = !vld_reg[2] || adv3;
    assign adv1     = !vld_reg[1] || adv2;
    assign adv0     = !vld_reg[0] || adv1;
    assign in_ready = adv0;

    // stage 0: minutes, four-year cycles and weeks as products
    always_comb
    begin
        wdx0       = in_data.d2k + D2K_W'(WD_2000_OFS);
        pmin0_next = 31'(in_data.sod[SOD_W-1:2]) * 31'(RECIP_15_W);
        pcyc0_next = 33'(in_data.d2k) * 33'(RECIP_1461);
        pwd0_next  = 33'(wdx0) * 33'(RECIP_7);
    end

    // stage 1: quotients and remainders
    always_comb
    begin
        wdx1       = d2k0_reg + D2K_W'(WD_2000_OFS);
        mins1_next = pmin0_reg[29:SH_15_W];
        sec1_next  = 6'(sod0_reg - 17'(mins1_next) * 17'd60);
        cyc1_next  = pcyc0_reg[31:SH_1461];
        r1_next    = 11'(d2k0_reg - 16'(cyc1_next) * 16'd1461);
        q7         = pwd0_reg[31:SH_7];
        wd1_next   = 3'(wdx1 - 16'(q7) * 16'd7) + 3'd1;
    end

    // stage 2: hour product, year inside the cycle (first year is leap)
    always_comb
    begin
        phr2_next = 19'(mins1_reg[10:2]) * 19'(RECIP_15_N);
        if (r1_reg < 11'd366)
        begin
            yi        = 2'd0;
            doy2_next = 9'(r1_reg);
        end
        else if (r1_reg < 11'd731)
        begin
            yi        = 2'd1;
            doy2_next = 9'(r1_reg - 11'd366);
        end
        else if (r1_reg < 11'd1096)
        begin
            yi        = 2'd2;
            doy2_next = 9'(r1_reg - 11'd731);
        end
        else
        begin
            yi        = 2'd3;
            doy2_next = 9'(r1_reg - 11'd1096);
        end
        leap2_next = (yi == 2'd0);
        year2_next = YEAR_BASE + YEAR_W'({cyc1_reg, 2'b00}) + YEAR_W'(yi);
    end

    // stage 3: hour / minute, month and day
    always_comb
    begin
        hour3 = phr2_reg[17:SH_15_N];
        mi    = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy2_reg >= month_start(4'(i), leap2_reg))
            begin
                mi = 4'(i);
            end
        end
        mstart = month_start(mi, leap2_reg);

        res3_next = '0;
        if (ok2_reg)
        begin
            res3_next.valid_res    = 1'b1;
            res3_next.year         = year2_reg;
            res3_next.month        = mi + 4'd1;
            res3_next.day_of_month = 5'(doy2_reg - mstart) + 5'd1;
            res3_next.hour         = hour3;
            res3_next.minute       = 6'(mins2_reg - 11'(hour3) * 11'd60);
            res3_next.second       = sec2_reg;
            res3_next.weekday      = wd2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv0)
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv1)
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (adv2)
            begin
                vld_reg[2] <= vld_reg[1];
            end
            if (adv3)
            begin
                vld_reg[3] <= vld_reg[2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            pmin0_reg <= pmin0_next;
            pcyc0_reg <= pcyc0_next;
            pwd0_reg  <= pwd0_next;
            sod0_reg  <= in_data.sod;
            d2k0_reg  <= in_data.d2k;
            ok0_reg   <= in_data.ok;
        end
        if (adv1)
        begin
            mins1_reg <= mins1_next;
            sec1_reg  <= sec1_next;
            cyc1_reg  <= cyc1_next;
            r1_reg    <= r1_next;
            wd1_reg   <= wd1_next;
            ok1_reg   <= ok0_reg;
        end
        if (adv2)
        begin
            phr2_reg  <= phr2_next;
            mins2_reg <= mins1_reg;
            sec2_reg  <= sec1_reg;
            year2_reg <= year2_next;
            doy2_reg  <= doy2_next;
            leap2_reg <= leap2_next;
            wd2_reg   <= wd1_reg;
            ok2_reg   <= ok1_reg;
        end
        if (adv3)
        begin
            res3_reg <= res3_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_data  = res3_reg;

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.valid_res |->
            out_data.year >= YEAR_BASE && out_data.year <= 12'd2099)
        else $error("converted year outside 2000..2099");

    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.valid_res |->
            out_data.month >= 4'd1 && out_data.month <= 4'd12 &&
            out_data.day_of_month >= 5'd1 && out_data.weekday != 3'd0 &&
            out_data.hour <= 5'd23 && out_data.minute <= 6'd59 &&
            out_data.second <= 6'd59)
        else $error("calendar field out of range");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |-> out_data == '0)
        else $error("invalid word carries nonzero fields");

endmodule

>>> bench/tb_epoch_to_calendar_converter_core.sv
// ----------------------------------------------------------------------------
// tb_epoch_to_calendar_converter_core: self-checking bench for the converter
// Directed epochs around the 2000..2099 window, the zero epoch, negative local
// time and the offset extremes, then random epochs under several offsets.
// Every result word is checked field by field against a table or behavioral model.
// ----------------------------------------------------------------------------
module tb_epoch_to_calendar_converter_core;

    timeunit 1ns;
    timeprecision 1ps;

    import epc_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 12;   // extra wait after the result queue empties
    localparam int          PHASES      = 6;
    localparam int          PHASE_WORDS = 185;
    localparam logic [31:0] WIN_LO      = 32'd946619264;   // 2000-01-01 minus 2**16
    localparam logic [31:0] WIN_HI      = 32'd4102510335;  // 2099-12-31 end plus 2**16

    localparam result_t NO_DATE  = '0;
    localparam result_t Y2K_DATE = '{1'b1, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd6};
    localparam result_t END_DATE = '{1'b1, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd4};

    typedef struct {
        logic [OFFS_W-1:0]  offs;
        logic [EPOCH_W-1:0] epoch;
        bit                 typed;
        result_t            want;
    } dir_row_t;

    localparam int DIR_ROWS = 21;

    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{17'd0,        32'd0,          1'b1, NO_DATE},
        '{17'd0,        32'd1,          1'b1, NO_DATE},
        '{17'd0,        32'd946684799,  1'b1, NO_DATE},
        '{17'd0,        32'd946684800,  1'b1, Y2K_DATE},
        '{17'd0,        32'd951782400,  1'b0, NO_DATE},   // 2000-02-29
        '{17'd0,        32'd1709164800, 1'b0, NO_DATE},   // 2024-02-29
        '{17'd0,        32'd1700000000, 1'b0, NO_DATE},
        '{17'd0,        32'd4102444799, 1'b1, END_DATE},
        '{17'd0,        32'd4102444800, 1'b1, NO_DATE},
        '{17'd0,        32'hFFFFFFFF,   1'b1, NO_DATE},
        '{-17'sd43200,  32'd946684800,  1'b1, NO_DATE},
        '{-17'sd43200,  32'd100,        1'b1, NO_DATE},
        '{-17'sd43200,  32'd946728000,  1'b1, Y2K_DATE},
        '{17'd50400,    32'd946634400,  1'b1, Y2K_DATE},
        '{17'd50400,    32'd4102444799, 1'b1, NO_DATE},
        '{17'd50400,    32'd4102394399, 1'b1, END_DATE},
        '{17'h10000,    32'd65535,      1'b1, NO_DATE},
        '{17'h10000,    32'd65536,      1'b1, NO_DATE},
        '{17'h10000,    32'hFFFFFFFF,   1'b0, NO_DATE},
        '{17'h0FFFF,    32'd4102379264, 1'b1, END_DATE},
        '{17'h0FFFF,    32'd1,          1'b0, NO_DATE}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [OFFS_W-1:0]   cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [EPOCH_W-1:0]  utc_epoch;
    logic                out_valid;
    logic                out_ready;
    logic                valid_res;
    logic [YEAR_W-1:0]   year;
    logic [3:0]          month;
    logic [4:0]          day_of_month;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
    logic [2:0]          weekday;

    result_t             date_q[$];
    logic [OFFS_W-1:0]   cur_offs;
    bit                  calm;
    int                  err_cnt;
    int                  sent_cnt;
    int                  dated_cnt;
    int                  rejected_cnt;
    int                  offs_writes;
    int                  stall_cnt;

    epoch_to_calendar_converter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .utc_epoch    (utc_epoch),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .weekday      (weekday)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Civil date of local time; days-from-civil inverse on a March-based year.
    function automatic result_t civil_date(input logic [EPOCH_W-1:0] epoch,
                                           input logic [OFFS_W-1:0] offs);
        result_t r;
        longint  offs_s;
        longint  loc;
        longint  days;
        longint  sod;
        longint  z;
        longint  era;
        longint  doe;
        longint  yoe;
        longint  doy;
        longint  mp;
        longint  yr;
        longint  mo;
        longint  dd;
        begin
            r      = '0;
            offs_s = $signed(offs);
            loc    = longint'({32'd0, epoch}) + offs_s;
            if (epoch == '0 || loc < 0)
            begin
                return r;
            end
            days = loc / 86400;
            sod  = loc % 86400;
            z    = days + 719468;
            era  = z / 146097;
            doe  = z - era * 146097;
            yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp   = (5 * doy + 2) / 153;
            yr   = yoe + era * 400;
            dd   = doy - (153 * mp + 2) / 5 + 1;
            mo   = (mp < 10) ? mp + 3 : mp - 9;
            if (mo <= 2)
            begin
                yr = yr + 1;
            end
            if (yr < 2000 || yr > 2099)
            begin
                return r;
            end
            r.valid_res    = 1'b1;
            r.year         = 12'(yr);
            r.month        = 4'(mo);
            r.day_of_month = 5'(dd);
            r.hour         = 5'(sod / 3600);
            r.minute       = 6'((sod / 60) % 60);
            r.second       = 6'(sod % 60);
            r.weekday      = 3'((days + 3) % 7 + 1);   // 1970-01-01 was a Thursday
            return r;
        end
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        begin
            if (want != got)
            begin
                err_cnt++;
                $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
            end
        end
    endtask

    task automatic push_epoch(input logic [EPOCH_W-1:0] epoch, input bit typed,
                              input result_t want);
        begin
            while (!calm && $urandom_range(99) < 6)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            utc_epoch <= epoch;
            do
            begin
                @(posedge clk);
            end
            while (!in_ready);
            date_q.push_back(typed ? want : civil_date(epoch, cur_offs));
            sent_cnt++;
        end
    endtask

    // Offset changes only with the pipe empty.
    task automatic write_offset(input logic [OFFS_W-1:0] offs);
        begin
            in_valid <= 1'b0;
            while (date_q.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_WAIT) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= offs;
            @(posedge clk);
            cfg_we    <= 1'b0;
            cur_offs  = offs;
            offs_writes++;
        end
    endtask

    function automatic logic [EPOCH_W-1:0] pick_epoch();
        int unsigned sel;
        longint      e;
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                return $urandom_range(WIN_HI, WIN_LO);
            end
            else if (sel < 75)
            begin
                return $urandom();
            end
            else if (sel < 90)
            begin
                // straddle a local midnight inside the window
                e = longint'($urandom_range(47482, 10957)) * 86400
                    - longint'($signed(cur_offs)) + longint'($urandom_range(4)) - 2;
                return 32'(e);
            end
            else if (sel < 95)
            begin
                return $urandom_range(3);
            end
            else
            begin
                return 32'hFFFFFFFF - $urandom_range(3);
            end
        end
    endfunction

    function automatic logic [OFFS_W-1:0] pick_offset(input int phase);
        begin
            case (phase)
                0:       return 17'd0;
                1:       return -17'sd43200;
                2:       return 17'd50400;
                4:       return 17'($urandom());
                default: return 17'($urandom_range(93600) - 43200);
            endcase
        end
    endfunction

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (date_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: result word with none expected, valid_res %0b year %0d",
                         $time, valid_res, year);
            end
            else
            begin
                want = date_q.pop_front();
                check_field("valid_res", want.valid_res, valid_res);
                check_field("year", want.year, year);
                check_field("month", want.month, month);
                check_field("day_of_month", want.day_of_month, day_of_month);
                check_field("hour", want.hour, hour);
                check_field("minute", want.minute, minute);
                check_field("second", want.second, second);
                check_field("weekday", want.weekday, weekday);
                if (want.valid_res)
                begin
                    dated_cnt++;
                end
                else
                begin
                    rejected_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cnt <= 0;
        end
        else if (stall_cnt == STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        utc_epoch    = '0;
        out_ready    = 1'b0;
        cur_offs     = '0;
        calm         = 1'b0;
        err_cnt      = 0;
        sent_cnt     = 0;
        dated_cnt    = 0;
        rejected_cnt = 0;
        offs_writes  = 0;
        stall_cnt    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].offs != cur_offs)
            begin
                write_offset(dir_tbl[i].offs);
            end
            push_epoch(dir_tbl[i].epoch, dir_tbl[i].typed, dir_tbl[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_offset(pick_offset(ph));
            calm = (ph == 2);   // one phase runs back to back on both sides
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                push_epoch(pick_epoch(), 1'b0, NO_DATE);
            end
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (date_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d epochs under %0d offset settings", sent_cnt, offs_writes);
        $display("Result words: %0d dated, %0d rejected", dated_cnt, rejected_cnt);
        if (err_cnt == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
